// ----- hw/rtl/kch_pkg.sv -----
// Shared types and constants for the k-mer count histogram.
package kch_pkg;

    localparam int HIST_AW = 16;
    localparam int COUNT_W = 32;
    localparam int CODE_W  = 16;
    localparam int RUN_W   = 4;

    localparam logic [RUN_W-1:0]   RUN_MAX      = 4'd15;
    localparam logic [COUNT_W-1:0] THRESH_RESET = 32'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_result;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

// ----- hw/rtl/kmer_count_histogram_top.sv -----
// Top level of the k-mer count histogram: controller and datapath.
// Each request passes through a transfer cycle, in which the histogram entry is read
// from the memory's registered read port, and an update cycle, in which the entry of a
// counted push is incremented and written back, and the count is compared with the
// threshold before the result is registered. The next transfer is taken in the cycle
// after the update, so no new item is taken before the last one is through; a stalled
// output holds the update step. After reset the 65536-entry histogram is cleared one
// entry per cycle, and no request is taken during that clearing pass; threshold writes are taken throughout.
module kmer_count_histogram_top #(
    parameter int KMER_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  base_char,
    input  logic [15:0] read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] kmer_code,
    output logic        kmer_counted,
    output logic [31:0] count_value,
    output logic        is_frequent
);

    kch_pkg::cmd_t cmd;
    kch_pkg::sts_t sts;

    kch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kch_datapath #(
        .KMER_LEN (KMER_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (req_type),
        .base_char    (base_char),
        .read_index   (read_index),
        .kmer_code    (kmer_code),
        .kmer_counted (kmer_counted),
        .count_value  (count_value),
        .is_frequent  (is_frequent)
    );

endmodule

// ----- hw/rtl/kch_ctrl.sv -----
// Controller state machine: clearing pass, item acceptance and result hand-off.
module kch_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  kch_pkg::sts_t sts,
    output kch_pkg::cmd_t cmd
);

    kch_pkg::state_t state_reg;
    kch_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kch_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = kch_pkg::ST_IDLE;
                end
            end
            kch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kch_pkg::ST_UPDATE;
                end
            end
            kch_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = kch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kch_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.load_result = 1'b0;
        cmd.clear_wr    = 1'b0;
        case (state_reg)
            kch_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            kch_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            kch_pkg::ST_UPDATE:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kch_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted transfer always moves on to the update step.
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == kch_pkg::ST_UPDATE))
        else $error("accepted item did not reach update");

    // No item is taken while the histogram is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kch_pkg::ST_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    // The clearing pass only ends on its last address.
    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kch_pkg::ST_CLEAR && !sts.clear_last)
            |=> (state_reg == kch_pkg::ST_CLEAR))
        else $error("clearing pass ended early");

    // Completing an update always presents a result.
    a_update_presents: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("update finished without a result");

endmodule

// ----- hw/rtl/kch_datapath.sv -----
// Datapath: rolling k-mer register, histogram memory, increment and threshold compare.
module kch_datapath #(
    parameter int KMER_LEN = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  kch_pkg::cmd_t cmd,
    output kch_pkg::sts_t sts,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data,
    input  logic          req_type,
    input  logic [7:0]    base_char,
    input  logic [15:0]   read_index,
    output logic [15:0]   kmer_code,
    output logic          kmer_counted,
    output logic [31:0]   count_value,
    output logic          is_frequent
);

    localparam int CODE_BITS = (2 * KMER_LEN > kch_pkg::CODE_W) ? kch_pkg::CODE_W : 2 * KMER_LEN;
    localparam int RUN_NEED_INT = (KMER_LEN > 15) ? 15 : KMER_LEN;
    localparam logic [kch_pkg::CODE_W-1:0] CODE_MASK =
        kch_pkg::CODE_W'((64'd1 << CODE_BITS) - 64'd1);
    localparam logic [kch_pkg::RUN_W-1:0] RUN_NEED = kch_pkg::RUN_W'(RUN_NEED_INT);

    logic [kch_pkg::COUNT_W-1:0] hist_mem [2**kch_pkg::HIST_AW];

    logic [kch_pkg::COUNT_W-1:0] thresh_reg;
    logic [kch_pkg::CODE_W-1:0]  kmer_shift_reg;
    logic [kch_pkg::CODE_W-1:0]  kmer_shift_next;
    logic [kch_pkg::RUN_W-1:0]   valid_run_reg;
    logic [kch_pkg::RUN_W-1:0]   valid_run_next;
    logic [kch_pkg::HIST_AW-1:0] clr_addr_reg;

    logic [kch_pkg::COUNT_W-1:0] rd_data_reg;
    logic [kch_pkg::CODE_W-1:0]  code_reg;
    logic                        counted_reg;
    logic                        is_read_reg;

    logic [kch_pkg::CODE_W-1:0]  res_code_reg;
    logic                        res_counted_reg;
    logic [kch_pkg::COUNT_W-1:0] res_count_reg;
    logic                        res_freq_reg;

    logic [7:0]                  ch_upper;
    logic                        is_letter;
    logic                        is_base;
    logic [1:0]                  base_code;
    logic [kch_pkg::CODE_W-1:0]  shifted_code;
    logic [kch_pkg::RUN_W-1:0]   run_inc;
    logic                        push_counts;
    logic [kch_pkg::CODE_W-1:0]  item_code;
    logic [kch_pkg::HIST_AW-1:0] rd_addr;
    logic [kch_pkg::COUNT_W-1:0] inc_count;
    logic [kch_pkg::COUNT_W-1:0] upd_count;
    logic                        mem_we;
    logic [kch_pkg::HIST_AW-1:0] wr_addr;
    logic [kch_pkg::COUNT_W-1:0] wr_data;

    // Decode of the incoming byte.
    always_comb
    begin
        if (base_char >= kch_pkg::CHAR_LOWER_A && base_char <= kch_pkg::CHAR_LOWER_Z)
        begin
            ch_upper = base_char - kch_pkg::CASE_OFFSET;
        end
        else
        begin
            ch_upper = base_char;
        end
        is_letter = (ch_upper >= kch_pkg::CHAR_UPPER_A) && (ch_upper <= kch_pkg::CHAR_UPPER_Z);
        is_base   = 1'b1;
        case (ch_upper)
            kch_pkg::CHAR_UPPER_A: base_code = kch_pkg::BASE_A;
            kch_pkg::CHAR_C:       base_code = kch_pkg::BASE_C;
            kch_pkg::CHAR_G:       base_code = kch_pkg::BASE_G;
            kch_pkg::CHAR_T:       base_code = kch_pkg::BASE_T;
            default:
            begin
                base_code = kch_pkg::BASE_A;
                is_base   = 1'b0;
            end
        endcase
    end

    assign shifted_code = {kmer_shift_reg[kch_pkg::CODE_W-3:0], base_code} & CODE_MASK;
    assign run_inc      = (valid_run_reg < kch_pkg::RUN_MAX) ? valid_run_reg + 1'b1
                                                             : valid_run_reg;

    // Next k-mer state and the code reported for this item.
    always_comb
    begin
        kmer_shift_next = kmer_shift_reg;
        valid_run_next  = valid_run_reg;
        push_counts     = 1'b0;
        if (req_type == kch_pkg::REQ_READ)
        begin
            item_code = read_index;
        end
        else if (is_letter && is_base)
        begin
            kmer_shift_next = shifted_code;
            valid_run_next  = run_inc;
            push_counts     = (run_inc >= RUN_NEED);
            item_code       = shifted_code;
        end
        else if (is_letter)
        begin
            kmer_shift_next = '0;
            valid_run_next  = '0;
            item_code       = '0;
        end
        else
        begin
            item_code = kmer_shift_reg;
        end
    end

    assign rd_addr = item_code[kch_pkg::HIST_AW-1:0];

    assign inc_count = (rd_data_reg == kch_pkg::COUNT_MAX) ? rd_data_reg
                                                           : rd_data_reg + 1'b1;

    always_comb
    begin
        if (counted_reg)
        begin
            upd_count = inc_count;
        end
        else if (is_read_reg)
        begin
            upd_count = rd_data_reg;
        end
        else
        begin
            upd_count = '0;
        end
    end

    assign mem_we  = cmd.clear_wr || (cmd.load_result && counted_reg);
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : code_reg[kch_pkg::HIST_AW-1:0];
    assign wr_data = cmd.clear_wr ? '0 : inc_count;

    assign sts.clear_last = (clr_addr_reg == {kch_pkg::HIST_AW{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= kch_pkg::THRESH_RESET;
            kmer_shift_reg <= '0;
            valid_run_reg  <= '0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (cmd.accept && req_type == kch_pkg::REQ_PUSH)
            begin
                kmer_shift_reg <= kmer_shift_next;
                valid_run_reg  <= valid_run_next;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Histogram memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg    <= item_code;
            counted_reg <= (req_type == kch_pkg::REQ_PUSH) && push_counts;
            is_read_reg <= (req_type == kch_pkg::REQ_READ);
        end
        if (cmd.load_result)
        begin
            res_code_reg    <= code_reg;
            res_counted_reg <= counted_reg;
            res_count_reg   <= upd_count;
            res_freq_reg    <= (counted_reg || is_read_reg) && (upd_count > thresh_reg);
        end
    end

    assign kmer_code    = res_code_reg;
    assign kmer_counted = res_counted_reg;
    assign count_value  = res_count_reg;
    assign is_frequent  = res_freq_reg;

    // A counted k-mer can never report a zero count, as the increment saturates.
    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_result && counted_reg) |=> (res_count_reg != '0))
        else $error("counted k-mer reported a zero count");

endmodule
